// ===== src/quaternion_interpolation_macros.svh =====
// Assertion macros for the quaternion interpolation block.
// They expect clk and rst_n in scope.
`ifndef QUATERNION_INTERPOLATION_MACROS_SVH
`define QUATERNION_INTERPOLATION_MACROS_SVH
`ifndef SYNTHESIS
`define QI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion_interpolation: assertion failed");
`define QI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion_interpolation: assertion failed");
`else
`define QI_ASSERT_IMPL(label, ante, cons)
`define QI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/qi_pkg.sv =====
package qi_pkg;

    localparam int COMP_W    = 16;
    localparam int T_W       = 17;
    localparam int EPS_W     = 31;
    localparam int Q30_W     = 31;
    localparam int COS_W     = 30;
    localparam int DOT_W     = 36;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int Q30_SHIFT = 30 - 2 * (COMP_W - 2);
    localparam int RAD_W     = 62;
    localparam int ROOT_W    = 31;

    localparam logic [EPS_W-1:0] EPS_RESET = 31'd107374;
    localparam logic [T_W-1:0]   T_ONE     = 17'd65536;
    localparam logic [Q30_W-1:0] Q30_ONE   = 31'h4000_0000;

    localparam logic OP_LERP  = 1'b0;
    localparam logic OP_SLERP = 1'b1;

    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 36;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 36'sd652032874;

    localparam logic [Q30_W-1:0] ATAN_Q30 [CORDIC_ITERS] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
        31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
        31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128,       31'd64,
        31'd32,        31'd16,        31'd8,         31'd4,         31'd2
    };

    // unit latencies and the cycles at which values meet
    localparam int ISQRT_LAT = ROOT_W;
    localparam int ATAN_LAT  = CORDIC_ITERS;
    localparam int SIN_LAT   = CORDIC_ITERS;
    localparam int DIV_LAT   = Q30_W + 2;
    localparam int SIDE_AT   = 4;
    localparam int SQ_IN     = 5;
    localparam int ATAN_IN   = SQ_IN + ISQRT_LAT;
    localparam int MUL_IN    = ATAN_IN + ATAN_LAT;
    localparam int SIN_IN    = MUL_IN + 1;
    localparam int DIV_IN    = SIN_IN + SIN_LAT;
    localparam int DIV_OUT   = DIV_IN + DIV_LAT;
    localparam int TOTAL_LAT = DIV_OUT + 3;

    typedef struct packed {
        logic                     opcode;
        logic signed [COMP_W-1:0] start_x;
        logic signed [COMP_W-1:0] start_y;
        logic signed [COMP_W-1:0] start_z;
        logic signed [COMP_W-1:0] start_w;
        logic signed [COMP_W-1:0] end_x;
        logic signed [COMP_W-1:0] end_y;
        logic signed [COMP_W-1:0] end_z;
        logic signed [COMP_W-1:0] end_w;
        logic [T_W-1:0]           fraction;
    } request_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic signed [COMP_W-1:0] out_w;
    } result_t;

endpackage

// ===== src/quaternion_interpolation.sv =====
// Quaternion lerp/slerp engine. One request may be started in every clock
// cycle; busy is never raised. Each result appears on result for one cycle
// with done high, in request order, and cannot be held off. The pipeline
// depth is set by the spherical path: a 31-stage square root, two 30-stage
// CORDIC units and a 33-stage divider, one step per stage; linear requests
// go through the same pipeline. Write linear_fallback_epsilon only while no
// request is in flight.
`include "quaternion_interpolation_macros.svh"

module quaternion_interpolation (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  qi_pkg::request_t        request,
    output logic                    done,
    output qi_pkg::result_t         result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [qi_pkg::EPS_W-1:0] cfg_data
);
    import qi_pkg::*;

    typedef struct packed {
        logic [3:0][COMP_W-1:0] s;
        logic [3:0][COMP_W:0]   e;
        logic [T_W-1:0]         t;
        logic                   slerp;
    } side_t;

    logic [EPS_W-1:0]     eps_reg;
    logic [TOTAL_LAT-1:0] valid_reg;
    logic                 in_accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg   <= EPS_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], in_accept};
        end
    end

    // stage 1: products
    logic signed [COMP_W-1:0] in_s [4];
    logic signed [COMP_W-1:0] in_e [4];
    logic signed [PROD_W-1:0] s1_prod_reg [4];
    logic [3:0][COMP_W-1:0]   s1_s_reg, s1_e_reg;
    logic [T_W-1:0]           s1_t_reg;
    logic                     s1_op_reg;

    assign in_s[0] = request.start_x;
    assign in_s[1] = request.start_y;
    assign in_s[2] = request.start_z;
    assign in_s[3] = request.start_w;
    assign in_e[0] = request.end_x;
    assign in_e[1] = request.end_y;
    assign in_e[2] = request.end_z;
    assign in_e[3] = request.end_w;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            s1_prod_reg[i] <= PROD_W'(in_s[i]) * PROD_W'(in_e[i]);
            s1_s_reg[i]    <= in_s[i];
            s1_e_reg[i]    <= in_e[i];
        end
        s1_t_reg  <= (request.fraction > T_ONE) ? T_ONE : request.fraction;
        s1_op_reg <= request.opcode;
    end

    // stage 2: dot product in Q.30
    logic signed [DOT_W-1:0] dot_sum;
    logic signed [DOT_W-1:0] s2_dot_reg;
    logic [3:0][COMP_W-1:0]  s2_s_reg, s2_e_reg;
    logic [T_W-1:0]          s2_t_reg;
    logic                    s2_op_reg;

    always_comb
    begin
        dot_sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            dot_sum = dot_sum + (DOT_W'(s1_prod_reg[i]) <<< Q30_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dot_reg <= dot_sum;
        s2_s_reg   <= s1_s_reg;
        s2_e_reg   <= s1_e_reg;
        s2_t_reg   <= s1_t_reg;
        s2_op_reg  <= s1_op_reg;
    end

    // stage 3: shortest arc
    logic                   dot_neg;
    logic [DOT_W-1:0]       s3_cos_reg;
    logic [3:0][COMP_W-1:0] s3_s_reg;
    logic [3:0][COMP_W:0]   s3_e_reg;
    logic [T_W-1:0]         s3_t_reg;
    logic                   s3_op_reg;

    assign dot_neg = s2_dot_reg[DOT_W-1];

    always_ff @(posedge clk)
    begin
        s3_cos_reg <= dot_neg ? DOT_W'(-s2_dot_reg) : DOT_W'(s2_dot_reg);
        for (int i = 0; i < 4; i++)
        begin
            s3_e_reg[i] <= dot_neg ? -{s2_e_reg[i][COMP_W-1], s2_e_reg[i]}
                                   : {s2_e_reg[i][COMP_W-1], s2_e_reg[i]};
        end
        s3_s_reg  <= s2_s_reg;
        s3_t_reg  <= s2_t_reg;
        s3_op_reg <= s2_op_reg;
    end

    // stage 4: mode decision, cos^2
    logic signed [DOT_W:0]   cos_gap;
    side_t                   s4_side_reg;
    logic [2*COS_W-1:0]      s4_c2_reg;
    logic [Q30_W-1:0]        s4_cos_reg;

    assign cos_gap = $signed((DOT_W + 1)'(Q30_ONE)) - $signed({1'b0, s3_cos_reg});

    always_ff @(posedge clk)
    begin
        s4_side_reg.s     <= s3_s_reg;
        s4_side_reg.e     <= s3_e_reg;
        s4_side_reg.t     <= s3_t_reg;
        s4_side_reg.slerp <= (s3_op_reg == OP_SLERP)
                             && (cos_gap > $signed((DOT_W + 1)'(eps_reg)));
        s4_c2_reg  <= s3_cos_reg[COS_W-1:0] * s3_cos_reg[COS_W-1:0];
        s4_cos_reg <= s3_cos_reg[Q30_W-1:0];
    end

    // stage 5: 1 - cos^2
    logic [RAD_W-1:0] s5_rad_reg;
    logic [Q30_W-1:0] s5_cos_reg;

    always_ff @(posedge clk)
    begin
        s5_rad_reg <= (RAD_W'(1) << 60) - RAD_W'(s4_c2_reg);
        s5_cos_reg <= s4_cos_reg;
    end

    // sin(w), then w
    logic [ROOT_W-1:0]          sin_w;
    logic [Q30_W-1:0]           cos_dly;
    logic signed [CORDIC_W-1:0] omega;

    qi_isqrt u_isqrt (
        .clk  (clk),
        .rad  (s5_rad_reg),
        .root (sin_w)
    );

    qi_delay #(.WIDTH(Q30_W), .DEPTH(ISQRT_LAT)) u_cos_dly (
        .clk   (clk),
        .d_in  (s5_cos_reg),
        .d_out (cos_dly)
    );

    qi_cordic #(.VECTORING(1'b1)) u_atan (
        .clk        (clk),
        .x_in       ($signed(CORDIC_W'(cos_dly))),
        .y_in       ($signed(CORDIC_W'(sin_w))),
        .z_in       ('0),
        .cordic_out (omega)
    );

    // angles (1-t)w and tw
    localparam int AP_W = CORDIC_W + T_W + 1;
    logic [T_W-1:0]             t_dly;
    logic signed [AP_W-1:0]     ang_p, ang_q;
    logic signed [CORDIC_W-1:0] ap_reg, aq_reg;

    qi_delay #(.WIDTH(T_W), .DEPTH(MUL_IN - SIDE_AT)) u_t_dly (
        .clk   (clk),
        .d_in  (s4_side_reg.t),
        .d_out (t_dly)
    );

    assign ang_p = AP_W'(omega) * AP_W'($signed({1'b0, T_ONE - t_dly}));
    assign ang_q = AP_W'(omega) * AP_W'($signed({1'b0, t_dly}));

    always_ff @(posedge clk)
    begin
        ap_reg <= CORDIC_W'(ang_p >>> 16);
        aq_reg <= CORDIC_W'(ang_q >>> 16);
    end

    logic signed [CORDIC_W-1:0] sin_p, sin_q;
    logic [Q30_W-1:0]           sin_p_c, sin_q_c, sin_w_dly, w_p_sph, w_q_sph;

    qi_cordic #(.VECTORING(1'b0)) u_sin_p (
        .clk        (clk),
        .x_in       (CORDIC_K),
        .y_in       ('0),
        .z_in       (ap_reg),
        .cordic_out (sin_p)
    );

    qi_cordic #(.VECTORING(1'b0)) u_sin_q (
        .clk        (clk),
        .x_in       (CORDIC_K),
        .y_in       ('0),
        .z_in       (aq_reg),
        .cordic_out (sin_q)
    );

    assign sin_p_c = sin_p[CORDIC_W-1] ? '0
                   : (sin_p > $signed(CORDIC_W'(Q30_ONE))) ? Q30_ONE : sin_p[Q30_W-1:0];
    assign sin_q_c = sin_q[CORDIC_W-1] ? '0
                   : (sin_q > $signed(CORDIC_W'(Q30_ONE))) ? Q30_ONE : sin_q[Q30_W-1:0];

    qi_delay #(.WIDTH(Q30_W), .DEPTH(DIV_IN - ATAN_IN)) u_sinw_dly (
        .clk   (clk),
        .d_in  (sin_w),
        .d_out (sin_w_dly)
    );

    qi_div u_div_p (
        .clk   (clk),
        .numer (sin_p_c),
        .denom (sin_w_dly),
        .quot  (w_p_sph)
    );

    qi_div u_div_q (
        .clk   (clk),
        .numer (sin_q_c),
        .denom (sin_w_dly),
        .quot  (w_q_sph)
    );

    side_t side_dly;

    qi_delay #(.WIDTH($bits(side_t)), .DEPTH(DIV_OUT - SIDE_AT)) u_side_dly (
        .clk   (clk),
        .d_in  (s4_side_reg),
        .d_out (side_dly)
    );

    // weight select, weighted sum, round and saturate
    localparam int PP_W = COMP_W + Q30_W + 3;
    localparam int R_W  = PP_W - 30;
    logic [Q30_W-1:0]       wp_reg, wq_reg;
    logic [3:0][COMP_W-1:0] f1_s_reg;
    logic [3:0][COMP_W:0]   f1_e_reg;
    logic signed [PP_W-1:0] f2_pp_reg [4];
    logic signed [PP_W-1:0] f2_pq_reg [4];
    logic signed [PP_W-1:0] acc [4];
    logic signed [R_W-1:0]  rnd [4];
    logic signed [COMP_W-1:0] sat [4];
    result_t                out_reg;

    always_ff @(posedge clk)
    begin
        if (side_dly.slerp)
        begin
            wp_reg <= w_p_sph;
            wq_reg <= w_q_sph;
        end
        else
        begin
            wp_reg <= {T_ONE - side_dly.t, 14'b0};
            wq_reg <= {side_dly.t, 14'b0};
        end
        f1_s_reg <= side_dly.s;
        f1_e_reg <= side_dly.e;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            f2_pp_reg[i] <= PP_W'($signed(f1_s_reg[i])) * PP_W'($signed({1'b0, wp_reg}));
            f2_pq_reg[i] <= PP_W'($signed(f1_e_reg[i])) * PP_W'($signed({1'b0, wq_reg}));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc[i] = f2_pp_reg[i] + f2_pq_reg[i] + (PP_W'(1) <<< 29);
            rnd[i] = R_W'(acc[i] >>> 30);
            if (rnd[i] > $signed(R_W'({1'b0, {(COMP_W - 1){1'b1}}})))
            begin
                sat[i] = {1'b0, {(COMP_W - 1){1'b1}}};
            end
            else if (rnd[i] < -$signed(R_W'({1'b1, {(COMP_W - 1){1'b0}}})))
            begin
                sat[i] = {1'b1, {(COMP_W - 1){1'b0}}};
            end
            else
            begin
                sat[i] = rnd[i][COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg.out_x <= sat[0];
        out_reg.out_y <= sat[1];
        out_reg.out_z <= sat[2];
        out_reg.out_w <= sat[3];
    end

    assign result = out_reg;
    assign done   = valid_reg[TOTAL_LAT-1];

    `QI_ASSERT_IMPL(a_done_src, done, $past(start, TOTAL_LAT))
    `QI_ASSERT_IMPL(a_slerp_cos, valid_reg[SIDE_AT-1] && s4_side_reg.slerp, s4_cos_reg < Q30_ONE)
    `QI_ASSERT_NEXT(a_rad_pos, valid_reg[SIDE_AT-1] && s4_side_reg.slerp, s5_rad_reg != '0)
    `QI_ASSERT_IMPL(a_weight_max, valid_reg[DIV_OUT], (wp_reg <= Q30_ONE) && (wq_reg <= Q30_ONE))

endmodule

// ===== src/qi_delay.sv =====
module qi_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d_in,
    output logic [WIDTH-1:0] d_out
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        line_reg[0] <= d_in;
        for (int i = 1; i < DEPTH; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign d_out = line_reg[DEPTH-1];

endmodule

// ===== src/qi_isqrt.sv =====
module qi_isqrt (
    input  logic                      clk,
    input  logic [qi_pkg::RAD_W-1:0]  rad,
    output logic [qi_pkg::ROOT_W-1:0] root
);
    import qi_pkg::*;

    logic [RAD_W-1:0] rem_reg [ROOT_W];
    logic [RAD_W-1:0] res_reg [ROOT_W];

    // one result bit per stage
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [RAD_W-1:0] rem_cur, res_cur, trial, rem_next, res_next;

        if (k == 0)
        begin : g_first
            assign rem_cur = rad;
            assign res_cur = '0;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[k-1];
            assign res_cur = res_reg[k-1];
        end

        always_comb
        begin
            trial = res_cur + STEP_BIT;
            if (rem_cur >= trial)
            begin
                rem_next = rem_cur - trial;
                res_next = (res_cur >> 1) + STEP_BIT;
            end
            else
            begin
                rem_next = rem_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            res_reg[k] <= res_next;
        end
    end

    assign root = res_reg[ROOT_W-1][ROOT_W-1:0];

endmodule

// ===== src/qi_cordic.sv =====
module qi_cordic #(
    parameter bit VECTORING = 1'b0
) (
    input  logic                               clk,
    input  logic signed [qi_pkg::CORDIC_W-1:0] x_in,
    input  logic signed [qi_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [qi_pkg::CORDIC_W-1:0] z_in,
    output logic signed [qi_pkg::CORDIC_W-1:0] cordic_out
);
    import qi_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_ITERS];

    for (genvar k = 0; k < CORDIC_ITERS; k++)
    begin : g_iter
        logic signed [CORDIC_W-1:0] x_cur, y_cur, z_cur, dx, dy, ang;
        logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
        logic                       pos;

        if (k == 0)
        begin : g_first
            assign x_cur = x_in;
            assign y_cur = y_in;
            assign z_cur = z_in;
        end
        else
        begin : g_rest
            assign x_cur = x_reg[k-1];
            assign y_cur = y_reg[k-1];
            assign z_cur = z_reg[k-1];
        end

        always_comb
        begin
            dx  = y_cur >>> k;
            dy  = x_cur >>> k;
            ang = $signed({{(CORDIC_W - Q30_W){1'b0}}, ATAN_Q30[k]});
            pos = VECTORING ? ~y_cur[CORDIC_W-1] : ~z_cur[CORDIC_W-1];
            if (VECTORING == pos)
            begin
                x_next = x_cur + dx;
                y_next = y_cur - dy;
            end
            else
            begin
                x_next = x_cur - dx;
                y_next = y_cur + dy;
            end
            if (pos)
            begin
                z_next = VECTORING ? z_cur + ang : z_cur - ang;
            end
            else
            begin
                z_next = VECTORING ? z_cur - ang : z_cur + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[k] <= x_next;
            y_reg[k] <= y_next;
            z_reg[k] <= z_next;
        end
    end

    // vectoring gives the angle, rotation the sine
    assign cordic_out = VECTORING ? z_reg[CORDIC_ITERS-1] : y_reg[CORDIC_ITERS-1];

endmodule

// ===== src/qi_div.sv =====
module qi_div (
    input  logic                     clk,
    input  logic [qi_pkg::Q30_W-1:0] numer,
    input  logic [qi_pkg::Q30_W-1:0] denom,
    output logic [qi_pkg::Q30_W-1:0] quot
);
    import qi_pkg::*;

    logic [RAD_W-1:0] num0_reg, num1_reg;
    logic [Q30_W-1:0] den0_reg, den1_reg;
    logic             ovf1_reg;

    logic [RAD_W-1:0] rem_reg [Q30_W];
    logic [Q30_W-1:0] den_reg [Q30_W];
    logic [Q30_W-1:0] q_reg   [Q30_W];
    logic             ovf_reg [Q30_W];

    // rounded dividend: numer * 2^30 + denom / 2
    always_ff @(posedge clk)
    begin
        num0_reg <= {1'b0, numer, 30'b0} + RAD_W'(denom >> 1);
        den0_reg <= denom;
        num1_reg <= num0_reg;
        den1_reg <= den0_reg;
        ovf1_reg <= num0_reg >= {den0_reg, 31'b0};
    end

    for (genvar j = 0; j < Q30_W; j++)
    begin : g_step
        localparam int SH = Q30_W - 1 - j;
        logic [RAD_W-1:0] rem_cur, sub, rem_next;
        logic [Q30_W-1:0] den_cur, q_cur, q_next;
        logic             ovf_cur;

        if (j == 0)
        begin : g_first
            assign rem_cur = num1_reg;
            assign den_cur = den1_reg;
            assign q_cur   = '0;
            assign ovf_cur = ovf1_reg;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[j-1];
            assign den_cur = den_reg[j-1];
            assign q_cur   = q_reg[j-1];
            assign ovf_cur = ovf_reg[j-1];
        end

        always_comb
        begin
            sub      = RAD_W'(den_cur) << SH;
            rem_next = rem_cur;
            q_next   = q_cur;
            if (rem_cur >= sub)
            begin
                rem_next   = rem_cur - sub;
                q_next[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            den_reg[j] <= den_cur;
            q_reg[j]   <= q_next;
            ovf_reg[j] <= ovf_cur;
        end
    end

    assign quot = (ovf_reg[Q30_W-1] || q_reg[Q30_W-1] > Q30_ONE) ? Q30_ONE : q_reg[Q30_W-1];

endmodule

// ===== tb/tb_quaternion_interpolation.sv =====
`timescale 1ns / 100ps

class slerp_scoreboard;
    logic [qi_pkg::EPS_W-1:0] eps;
    qi_pkg::result_t          pending[$];
    int                       errors;
    int                       checked;
    int                       n_spherical;

    function new();
        eps = qi_pkg::EPS_RESET;
        errors = 0;
        checked = 0;
        n_spherical = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function longint angle_of(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < qi_pkg::CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += longint'(qi_pkg::ATAN_Q30[i]);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= longint'(qi_pkg::ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    function longint sine_of(longint z);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        for (int i = 0; i < qi_pkg::CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(qi_pkg::ATAN_Q30[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(qi_pkg::ATAN_Q30[i]);
            end
        end
        if (y < 0)
            y = 0;
        if (y > (64'sd1 <<< 30))
            y = 64'sd1 <<< 30;
        return y;
    endfunction

    function longint weight_of(longint sin_a, longint sin_w);
        longint w;
        w = ((sin_a <<< 30) + sin_w / 2) / sin_w;
        return (w > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : w;
    endfunction

    function qi_pkg::result_t interpolate(qi_pkg::request_t r);
        longint s[4];
        longint e[4];
        longint dot;
        longint cosv;
        longint t;
        longint wp;
        longint wq;
        longint sin_w;
        longint omega;
        longint acc;
        longint o[4];
        longint unsigned c2;
        qi_pkg::result_t res;
        s[0] = r.start_x; s[1] = r.start_y; s[2] = r.start_z; s[3] = r.start_w;
        e[0] = r.end_x;   e[1] = r.end_y;   e[2] = r.end_z;   e[3] = r.end_w;
        t = r.fraction;
        if (t > 65536)
            t = 65536;
        dot = 0;
        for (int i = 0; i < 4; i++)
            dot += (s[i] * e[i]) * 4;
        cosv = dot;
        if (dot < 0)
        begin
            cosv = -dot;
            for (int i = 0; i < 4; i++)
                e[i] = -e[i];
        end
        wp = (65536 - t) <<< 14;
        wq = t <<< 14;
        if (r.opcode == qi_pkg::OP_SLERP && ((64'sd1 <<< 30) - cosv) > longint'(eps))
        begin
            n_spherical++;
            c2 = longint'(cosv) * longint'(cosv);
            sin_w = int_sqrt((64'd1 << 60) - c2);
            omega = angle_of(sin_w, cosv);
            wp = weight_of(sine_of((omega * (65536 - t)) >>> 16), sin_w);
            wq = weight_of(sine_of((omega * t) >>> 16), sin_w);
        end
        for (int i = 0; i < 4; i++)
        begin
            acc = (s[i] * wp + e[i] * wq + (64'sd1 <<< 29)) >>> 30;
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            o[i] = acc;
        end
        res.out_x = o[0][15:0];
        res.out_y = o[1][15:0];
        res.out_z = o[2][15:0];
        res.out_w = o[3][15:0];
        return res;
    endfunction

    function void note_request(qi_pkg::request_t r);
        pending.push_back(interpolate(r));
    endfunction

    function void check_result(qi_pkg::result_t got);
        qi_pkg::result_t exp;
        if (pending.size() == 0)
        begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        checked++;
        if (got.out_x !== exp.out_x)
        begin
            $error("out_x expected %0d got %0d", exp.out_x, got.out_x);
            errors++;
        end
        if (got.out_y !== exp.out_y)
        begin
            $error("out_y expected %0d got %0d", exp.out_y, got.out_y);
            errors++;
        end
        if (got.out_z !== exp.out_z)
        begin
            $error("out_z expected %0d got %0d", exp.out_z, got.out_z);
            errors++;
        end
        if (got.out_w !== exp.out_w)
        begin
            $error("out_w expected %0d got %0d", exp.out_w, got.out_w);
            errors++;
        end
    endfunction
endclass

module tb_quaternion_interpolation;
    import qi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    request_t            request;
    logic                done;
    result_t             result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [EPS_W-1:0]    cfg_data;
    int                  cycles;
    int                  burst_left;
    slerp_scoreboard     sb;

    quaternion_interpolation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(request);
            if (done)
                sb.check_result(result);
            if (cfg_valid && cfg_ready)
                sb.eps = cfg_data;
        end
    end

    function automatic logic signed [COMP_W-1:0] any_comp(int span);
        return COMP_W'($urandom_range(2 * span) - span);
    endfunction

    function automatic logic [T_W-1:0] any_fraction();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return T_ONE;
        if (sel == 2)
            return T_W'($urandom);
        return T_W'($urandom_range(65536));
    endfunction

    function automatic request_t random_request();
        request_t r;
        int sel;
        int span;
        sel = $urandom_range(9);
        span = (sel < 2) ? 32768 : 8192;
        r = '0;
        r.opcode = ($urandom_range(3) == 0) ? OP_LERP : OP_SLERP;
        r.start_x = any_comp(span);
        r.start_y = any_comp(span);
        r.start_z = any_comp(span);
        r.start_w = any_comp(span);
        if (sel >= 7)
        begin
            r.end_x = r.start_x + any_comp(64);
            r.end_y = r.start_y + any_comp(64);
            r.end_z = r.start_z + any_comp(64);
            r.end_w = r.start_w + any_comp(64);
        end
        else
        begin
            r.end_x = any_comp(span);
            r.end_y = any_comp(span);
            r.end_z = any_comp(span);
            r.end_w = any_comp(span);
        end
        if (sel == 9)
            {r.end_x, r.end_y, r.end_z, r.end_w} =
                {-r.end_x, -r.end_y, -r.end_z, -r.end_w};
        r.fraction = any_fraction();
        return r;
    endfunction

    task automatic send_request(request_t r);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1))
                @(posedge clk);
            burst_left = (($urandom_range(3) == 0) ? 40 : 1) + $urandom_range(12);
        end
        burst_left--;
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 10)
            @(posedge clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_requests();
        request_t r;
        logic signed [COMP_W-1:0] q;
        for (int k = 0; k < 20; k++)
        begin
            r.opcode = (k % 2 == 0) ? OP_SLERP : OP_LERP;
            q = (k < 4) ? 16'sh7FFF : (k < 8) ? 16'sh8000 : 16'sd8192;
            r.start_x = q;
            r.start_y = (k < 8) ? q : 16'sd0;
            r.start_z = (k < 8) ? q : 16'sd0;
            r.start_w = (k < 8) ? q : 16'sd8192;
            r.end_x = (k % 4 < 2) ? r.start_x : -r.start_x;
            r.end_y = (k >= 12) ? 16'sd12000 : r.start_y;
            r.end_z = (k >= 16) ? 16'sh8000 : 16'sd0;
            r.end_w = (k == 10 || k == 11) ? 16'sd0 : r.start_w;
            if (k == 10 || k == 11)
                r.end_x = 16'sd0;
            case (k % 5)
                0: r.fraction = '0;
                1: r.fraction = T_ONE;
                2: r.fraction = 17'h1FFFF;
                3: r.fraction = 17'd32768;
                default: r.fraction = 17'd65537;
            endcase
            send_request(r);
        end
    endtask

    initial
    begin
        logic [EPS_W-1:0] eps_steps[5];
        sb = new();
        cycles = 0;
        burst_left = 0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        eps_steps[0] = EPS_RESET;
        eps_steps[1] = '0;
        eps_steps[2] = 31'h4000_0000;
        eps_steps[3] = EPS_W'($urandom_range(1 << 24));
        eps_steps[4] = EPS_W'($urandom_range(32'h4000_0000));
        directed_requests();
        for (int p = 0; p < 5; p++)
        begin
            if (p != 0)
            begin
                settle();
                write_epsilon(eps_steps[p]);
            end
            for (int n = 0; n < 246; n++)
                send_request(random_request());
        end
        settle();

        $display("Checked %0d interpolations (%0d spherical) over %0d epsilon settings.",
                 sb.checked, sb.n_spherical, 5);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
